### design/dda_pkg.sv
// Shared types for the DDA line rasterizer: controller states and control/status bundles.
`default_nettype none

package dda_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic div_last;
    logic pix_last;
  } ctl_sts_t;

endpackage

`default_nettype wire

### design/dda_ctrl.sv
// Sequencer for the DDA line rasterizer: load, serial divide, pixel emission.
`default_nettype none

module dda_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  output logic                   strobe_o,
  output dda_pkg::ctl_cmd_t      cmd_o,
  input  wire dda_pkg::ctl_sts_t sts_i
);

  dda_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dda_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    busy     = 1'b1;
    strobe_o = 1'b0;
    unique case (state_q)
      dda_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = dda_pkg::ST_DIV;
        end
      end
      dda_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = dda_pkg::ST_EMIT;
        end
      end
      dda_pkg::ST_EMIT: begin
        cmd_o.emit = 1'b1;
        strobe_o   = 1'b1;
        if (sts_i.pix_last) begin
          state_d = dda_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dda_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/dda_datapath.sv
// Datapath: endpoint setup, two bit-serial restoring dividers, accumulators and rounding.
`default_nettype none

module dda_datapath #(
  parameter int COORD_BITS = 6,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire dda_pkg::ctl_cmd_t            cmd_i,
  output dda_pkg::ctl_sts_t                 sts_o,
  input  wire logic signed [COORD_BITS-1:0] x_start_i,
  input  wire logic signed [COORD_BITS-1:0] y_start_i,
  input  wire logic signed [COORD_BITS-1:0] x_end_i,
  input  wire logic signed [COORD_BITS-1:0] y_end_i,
  output logic signed [COORD_BITS-1:0]      pixel_x_o,
  output logic signed [COORD_BITS-1:0]      pixel_y_o,
  output logic                              last_pixel_o
);

  localparam int CB       = COORD_BITS;
  localparam int DW       = COORD_BITS + FRAC_BITS;  // dividend / quotient width
  localparam int AW       = COORD_BITS + FRAC_BITS + 1;  // accumulator width
  localparam int CntW     = $clog2(DW + 1);
  localparam logic [CntW-1:0] DivLast = CntW'(DW - 1);
  localparam logic [AW-1:0]   Half    = AW'(1) << (FRAC_BITS - 1);

  // setup from the input item
  logic [1:0][CB:0]   diff;
  logic [1:0][CB-1:0] dmag;
  logic [1:0][CB-1:0] start_c;
  logic [CB-1:0]      n_c;

  assign start_c[0] = x_start_i;
  assign start_c[1] = y_start_i;
  assign diff[0] = {x_end_i[CB-1], x_end_i} - {x_start_i[CB-1], x_start_i};
  assign diff[1] = {y_end_i[CB-1], y_end_i} - {y_start_i[CB-1], y_start_i};

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      dmag[a] = diff[a][CB] ? CB'(-diff[a]) : diff[a][CB-1:0];
    end
    n_c = (dmag[0] >= dmag[1]) ? dmag[0] : dmag[1];
  end

  // registers
  logic [CB-1:0]        n_q;
  logic [CB-1:0]        k_q;
  logic [CntW-1:0]      cnt_q;
  logic [1:0]           neg_q;
  logic [1:0][CB-1:0]   rem_q, rem_d;
  logic [1:0][DW-1:0]   dq_q, dq_d;
  logic [1:0][AW-1:0]   acc_q;
  logic [1:0][AW-1:0]   inc;
  logic [1:0][CB:0]     trial;
  logic [1:0]           ge;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      trial[a] = {rem_q[a], dq_q[a][DW-1]};
      ge[a]    = trial[a] >= {1'b0, n_q};
      rem_d[a] = ge[a] ? CB'(trial[a] - {1'b0, n_q}) : trial[a][CB-1:0];
      dq_d[a]  = {dq_q[a][DW-2:0], ge[a]};
      inc[a]   = neg_q[a] ? AW'(-{{(AW-FRAC_BITS-1){1'b0}}, dq_q[a][FRAC_BITS:0]})
                          : {{(AW-FRAC_BITS-1){1'b0}}, dq_q[a][FRAC_BITS:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      k_q   <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= '0;
      k_q   <= '0;
    end else begin
      if (cmd_i.div_step) cnt_q <= cnt_q + CntW'(1);
      if (cmd_i.emit)     k_q   <= k_q + CB'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q <= n_c;
      for (int a = 0; a < 2; a++) begin
        neg_q[a] <= diff[a][CB];
        rem_q[a] <= '0;
        dq_q[a]  <= {dmag[a], {FRAC_BITS{1'b0}}};
        acc_q[a] <= {start_c[a][CB-1], start_c[a], {FRAC_BITS{1'b0}}};
      end
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      dq_q  <= dq_d;
    end else if (cmd_i.emit) begin
      for (int a = 0; a < 2; a++) begin
        acc_q[a] <= acc_q[a] + inc[a];
      end
    end
  end

  assign sts_o.div_last = (cnt_q == DivLast);
  assign sts_o.pix_last = (k_q == n_q);

  // round half away from zero
  logic [1:0][AW-1:0] amag;
  logic [1:0][AW-1:0] rsum;
  logic [1:0][CB-1:0] pix;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      amag[a] = acc_q[a][AW-1] ? AW'(-acc_q[a]) : acc_q[a];
      rsum[a] = (amag[a] + Half) >> FRAC_BITS;
      pix[a]  = acc_q[a][AW-1] ? CB'(-rsum[a][CB-1:0]) : rsum[a][CB-1:0];
    end
  end

  assign pixel_x_o    = pix[0];
  assign pixel_y_o    = pix[1];
  assign last_pixel_o = sts_o.pix_last;

endmodule

`default_nettype wire

### design/dda_line_rasterizer.sv
// Top level of the DDA line rasterizer: controller plus datapath.
// Usage:
//   Command channel: drive x_start_i, y_start_i, x_end_i, y_end_i and raise start;
//   the item is taken at a rising edge with start high and busy low.
//   Result channel: strobe_o is high for one cycle per pixel, with pixel_x_o,
//   pixel_y_o and last_pixel_o valid in that cycle; the receiver cannot stall.
//   Pixels run from the start point to the end point, last_pixel_o marks the
//   end point. Equal endpoints give the start pixel alone.
// Timing:
//   After acceptance the two axis increments come from bit-serial restoring
//   dividers working in parallel, one quotient bit per cycle. Then n+1 pixels
//   follow, one per cycle, n being the larger absolute axis difference; busy
//   is high from acceptance until the cycle after the last pixel.
// Reset: asynchronous, active low; returns to idle, any item in flight is dropped.
`default_nettype none

module dda_line_rasterizer #(
  parameter int COORD_BITS = 6,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [COORD_BITS-1:0] x_start_i,
  input  wire logic signed [COORD_BITS-1:0] y_start_i,
  input  wire logic signed [COORD_BITS-1:0] x_end_i,
  input  wire logic signed [COORD_BITS-1:0] y_end_i,
  output logic                              strobe_o,
  output logic signed [COORD_BITS-1:0]      pixel_x_o,
  output logic signed [COORD_BITS-1:0]      pixel_y_o,
  output logic                              last_pixel_o
);

  dda_pkg::ctl_cmd_t cmd;
  dda_pkg::ctl_sts_t sts;

  dda_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .strobe_o (strobe_o),
    .cmd_o    (cmd),
    .sts_i    (sts)
  );

  dda_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .x_start_i    (x_start_i),
    .y_start_i    (y_start_i),
    .x_end_i      (x_end_i),
    .y_end_i      (y_end_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .last_pixel_o (last_pixel_o)
  );

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the DDA line rasterizer: directed and random segments.
`timescale 1ns / 1ps

module testbench;

  localparam int COORD_BITS   = 6;
  localparam int FRAC_BITS    = 16;
  localparam int RANDOM_ITEMS = 236;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int REPORT_LIMIT = 10;

  localparam longint ONE_FIXED  = longint'(1) <<< FRAC_BITS;
  localparam longint HALF_FIXED = longint'(1) <<< (FRAC_BITS - 1);
  localparam int     COORD_MIN  = -(1 << (COORD_BITS - 1));
  localparam int     COORD_MAX  = (1 << (COORD_BITS - 1)) - 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

  logic   clk_i;
  logic   rst_ni;
  logic   start;
  logic   busy;
  coord_t x_start_i;
  coord_t y_start_i;
  coord_t x_end_i;
  coord_t y_end_i;
  logic   strobe_o;
  coord_t pixel_x_o;
  coord_t pixel_y_o;
  logic   last_pixel_o;

  pixel_t pending_pixels[$];
  int     pixel_errors;
  int     cycle_count;
  int     burst_left;

  dda_line_rasterizer #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .x_start_i   (x_start_i),
    .y_start_i   (y_start_i),
    .x_end_i     (x_end_i),
    .y_end_i     (y_end_i),
    .strobe_o    (strobe_o),
    .pixel_x_o   (pixel_x_o),
    .pixel_y_o   (pixel_y_o),
    .last_pixel_o(last_pixel_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // round half away from zero, then keep the low coordinate bits
  function automatic coord_t round_fixed(longint acc);
    longint mag;
    longint r;
    mag = (acc < 0) ? -acc : acc;
    r = (mag + HALF_FIXED) >>> FRAC_BITS;
    if (acc < 0) r = -r;
    return r[COORD_BITS-1:0];
  endfunction

  function automatic void rasterize_segment(coord_t xs, coord_t ys, coord_t xe, coord_t ye);
    longint dx;
    longint dy;
    longint steps;
    longint inc_x;
    longint inc_y;
    longint acc_x;
    longint acc_y;
    pixel_t p;
    dx = longint'(xe) - longint'(xs);
    dy = longint'(ye) - longint'(ys);
    steps = (dx < 0) ? -dx : dx;
    if (((dy < 0) ? -dy : dy) > steps) steps = (dy < 0) ? -dy : dy;
    if (steps == 0) begin
      p.x = xs;
      p.y = ys;
      p.last = 1'b1;
      pending_pixels.push_back(p);
      return;
    end
    // signed division truncates toward zero
    inc_x = (dx * ONE_FIXED) / steps;
    inc_y = (dy * ONE_FIXED) / steps;
    acc_x = longint'(xs) * ONE_FIXED;
    acc_y = longint'(ys) * ONE_FIXED;
    for (longint k = 0; k <= steps; k++) begin
      p.x = round_fixed(acc_x);
      p.y = round_fixed(acc_y);
      p.last = (k == steps);
      pending_pixels.push_back(p);
      acc_x += inc_x;
      acc_y += inc_y;
    end
  endfunction

  // one segment item; start stays high across a burst
  task automatic send_segment(coord_t xs, coord_t ys, coord_t xe, coord_t ye);
    int gap;
    start     <= 1'b1;
    x_start_i <= xs;
    y_start_i <= ys;
    x_end_i   <= xe;
    y_end_i   <= ye;
    do @(posedge clk_i); while (busy);
    rasterize_segment(xs, ys, xe, ye);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(1, 90);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic coord_t nudge(coord_t c);
    int v;
    v = int'(c) + $urandom_range(0, 12) - 6;
    if (v < COORD_MIN) v = COORD_MIN;
    if (v > COORD_MAX) v = COORD_MAX;
    return v[COORD_BITS-1:0];
  endfunction

  task automatic test_degenerate_segments();
    send_segment(0, 0, 0, 0);
    send_segment(-32, -32, -32, -32);
    send_segment(31, 31, 31, 31);
    send_segment(-32, 31, -32, 31);
  endtask

  task automatic test_axis_aligned_segments();
    send_segment(-32, 0, 31, 0);
    send_segment(0, -32, 0, 31);
    send_segment(31, 5, -32, 5);
    send_segment(5, 31, 5, -32);
  endtask

  task automatic test_full_span_diagonals();
    send_segment(-32, -32, 31, 31);
    send_segment(31, 31, -32, -32);
    send_segment(-32, 31, 31, -32);
    send_segment(31, -32, -32, 31);
  endtask

  // increments of exactly one half hit the tie in rounding
  task automatic test_half_rounding();
    send_segment(0, 0, 2, 1);
    send_segment(0, 0, 2, -1);
    send_segment(0, 0, -2, -1);
    send_segment(-3, -3, -1, -4);
  endtask

  task automatic test_octants();
    send_segment(0, 0, 7, 3);
    send_segment(0, 0, 3, 7);
    send_segment(0, 0, -3, 7);
    send_segment(0, 0, -7, 3);
    send_segment(0, 0, -7, -3);
    send_segment(0, 0, -3, -7);
    send_segment(0, 0, 3, -7);
    send_segment(0, 0, 7, -3);
  endtask

  task automatic test_random_segments(int count);
    coord_t xs;
    coord_t ys;
    coord_t xe;
    coord_t ye;
    int     kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 9);
      xs = coord_t'($urandom);
      ys = coord_t'($urandom);
      xe = coord_t'($urandom);
      ye = coord_t'($urandom);
      if (kind == 0) begin
        xe = xs;
        ye = ys;
      end else if (kind <= 3) begin
        xe = nudge(xs);
        ye = nudge(ys);
      end
      send_segment(xs, ys, xe, ye);
    end
  endtask

  always @(posedge clk_i) begin
    pixel_t got;
    pixel_t want;
    if (rst_ni && strobe_o) begin
      got = {pixel_x_o, pixel_y_o, last_pixel_o};
      if (pending_pixels.size() == 0) begin
        if (pixel_errors < REPORT_LIMIT)
          $display("unexpected pixel: x=%0d y=%0d last=%0b", got.x, got.y, got.last);
        pixel_errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (got !== want) begin
          if (pixel_errors < REPORT_LIMIT)
            $display("pixel mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                     want.x, want.y, want.last, got.x, got.y, got.last);
          pixel_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    pixel_errors = 0;
    cycle_count  = 0;
    burst_left   = $urandom_range(1, 12);
    rst_ni    <= 1'b0;
    start     <= 1'b0;
    x_start_i <= '0;
    y_start_i <= '0;
    x_end_i   <= '0;
    y_end_i   <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_degenerate_segments();
    test_axis_aligned_segments();
    test_full_span_diagonals();
    test_half_rounding();
    test_octants();
    test_random_segments(RANDOM_ITEMS);

    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (pixel_errors == 0 && pending_pixels.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
